### rtl/core/rtcsm_pkg.sv
// ----------------------------------------------------------------------------
// rtcsm_pkg
// Shared widths, action codes and transfer phase codes for the three-wire
// serial master.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcsm_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned PhaseW  = 2;

  // action codes of an input word
  localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
  localparam logic [ActionW-1:0] ACT_WRITE = 2'd1;
  localparam logic [ActionW-1:0] ACT_READ  = 2'd2;

  // transfer phases
  localparam logic [PhaseW-1:0] PH_IDLE  = 2'd0;
  localparam logic [PhaseW-1:0] PH_CMD   = 2'd1;
  localparam logic [PhaseW-1:0] PH_WDATA = 2'd2;
  localparam logic [PhaseW-1:0] PH_RDATA = 2'd3;

  localparam logic [BitIdxW-1:0] LAST_BIT = 3'd7;

endpackage

`default_nettype wire

### rtl/core/rtcsm_if.sv
// ----------------------------------------------------------------------------
// rtcsm channel interfaces
// Valid/ready channels for tick words in and line-level words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtcsm_in_if;
  logic                            valid;
  logic                            ready;
  logic [rtcsm_pkg::ActionW-1:0]   action;
  logic [rtcsm_pkg::ByteW-1:0]     command;
  logic [rtcsm_pkg::ByteW-1:0]     data;
  logic                            io_in;

  modport source (output valid, action, command, data, io_in, input ready);
  modport sink   (input valid, action, command, data, io_in, output ready);
endinterface

interface rtcsm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            chip_enable;
  logic                            serial_clock;
  logic                            io_out;
  logic                            io_drive;
  logic                            busy_res;
  logic                            done_res;
  logic [rtcsm_pkg::ByteW-1:0]     read_data;

  modport source (output valid, chip_enable, serial_clock, io_out, io_drive,
                  busy_res, done_res, read_data, input ready);
  modport sink   (input valid, chip_enable, serial_clock, io_out, io_drive,
                  busy_res, done_res, read_data, output ready);
endinterface

`default_nettype wire

### rtl/core/three_wire_rtc_serial_master_unit.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit
// Master for a three-wire serial link (enable, serial clock, data line).
// Every input word is one half-clock tick and yields one output word.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_chan   in    valid/ready    action, command, data, io_in
//  out_chan  out   valid/ready    chip_enable, serial_clock, io_out,
//                                 io_drive, busy_res, done_res, read_data
//
//  one word per cycle unless out_chan stalls: the tick state updates on
//  accept and the line levels land in the output register on the same edge
//  in_chan.ready is high whenever the output register is empty or drains
//  a stall on out_chan holds both the output word and the tick state
//  rst_n is synchronous: link idle, output register empty
// ----------------------------------------------------------------------------
`default_nettype none

module three_wire_rtc_serial_master_unit (
  input  wire              clk,
  input  wire              rst_n,
  rtcsm_in_if.sink         in_chan,
  rtcsm_out_if.source      out_chan
);

  logic [rtcsm_pkg::PhaseW-1:0]  phase_r, phase_nxt;
  logic [rtcsm_pkg::BitIdxW-1:0] bit_index_r, bit_index_nxt;
  logic                          clock_half_r, clock_half_nxt;
  logic [rtcsm_pkg::ByteW-1:0]   command_shift_r, command_shift_nxt;
  logic [rtcsm_pkg::ByteW-1:0]   data_shift_r, data_shift_nxt;
  logic [rtcsm_pkg::ByteW-1:0]   read_capture_r, read_capture_nxt;
  logic                          is_read_r, is_read_nxt;

  logic                          out_valid_r;
  logic                          ce_r, sclk_r, io_out_r, io_drive_r, done_r;
  logic                          ce_nxt, sclk_nxt, io_out_nxt, io_drive_nxt, done_nxt;

  logic accept;
  logic running;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign running       = (phase_r != rtcsm_pkg::PH_IDLE);

  always_comb begin
    phase_nxt         = phase_r;
    bit_index_nxt     = bit_index_r;
    clock_half_nxt    = clock_half_r;
    command_shift_nxt = command_shift_r;
    data_shift_nxt    = data_shift_r;
    read_capture_nxt  = read_capture_r;
    is_read_nxt       = is_read_r;
    done_nxt          = 1'b0;

    if (running) begin
      if (!clock_half_r) begin
        clock_half_nxt = 1'b1;
      end else begin
        clock_half_nxt = 1'b0;
        if (bit_index_r != rtcsm_pkg::LAST_BIT) begin
          bit_index_nxt = bit_index_r + 1'b1;
        end else begin
          bit_index_nxt = '0;
          if (phase_r == rtcsm_pkg::PH_CMD) begin
            phase_nxt = is_read_r ? rtcsm_pkg::PH_RDATA : rtcsm_pkg::PH_WDATA;
          end else begin
            phase_nxt = rtcsm_pkg::PH_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      // sample on the clock-low tick that follows a falling edge
      if (!done_nxt && phase_nxt == rtcsm_pkg::PH_RDATA && !clock_half_nxt &&
          in_chan.io_in) begin
        read_capture_nxt[bit_index_nxt] = 1'b1;
      end
    end else if (in_chan.action == rtcsm_pkg::ACT_WRITE ||
                 in_chan.action == rtcsm_pkg::ACT_READ) begin
      phase_nxt         = rtcsm_pkg::PH_CMD;
      bit_index_nxt     = '0;
      clock_half_nxt    = 1'b0;
      command_shift_nxt = in_chan.command;
      data_shift_nxt    = in_chan.data;
      read_capture_nxt  = '0;
      is_read_nxt       = (in_chan.action == rtcsm_pkg::ACT_READ);
    end

    // line levels follow the updated tick state
    ce_nxt       = (phase_nxt != rtcsm_pkg::PH_IDLE);
    sclk_nxt     = ce_nxt && clock_half_nxt;
    io_out_nxt   = 1'b0;
    io_drive_nxt = 1'b0;
    case (phase_nxt)
      rtcsm_pkg::PH_CMD: begin
        io_out_nxt   = command_shift_nxt[bit_index_nxt];
        io_drive_nxt = 1'b1;
      end
      rtcsm_pkg::PH_WDATA: begin
        io_out_nxt   = data_shift_nxt[bit_index_nxt];
        io_drive_nxt = 1'b1;
      end
      default: begin
        io_out_nxt   = 1'b0;
        io_drive_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= rtcsm_pkg::PH_IDLE;
      bit_index_r     <= '0;
      clock_half_r    <= 1'b0;
      command_shift_r <= '0;
      data_shift_r    <= '0;
      read_capture_r  <= '0;
      is_read_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        phase_r         <= phase_nxt;
        bit_index_r     <= bit_index_nxt;
        clock_half_r    <= clock_half_nxt;
        command_shift_r <= command_shift_nxt;
        data_shift_r    <= data_shift_nxt;
        read_capture_r  <= read_capture_nxt;
        is_read_r       <= is_read_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ce_r       <= ce_nxt;
      sclk_r     <= sclk_nxt;
      io_out_r   <= io_out_nxt;
      io_drive_r <= io_drive_nxt;
      done_r     <= done_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.chip_enable  = ce_r;
  assign out_chan.serial_clock = sclk_r;
  assign out_chan.io_out       = io_out_r;
  assign out_chan.io_drive     = io_drive_r;
  assign out_chan.busy_res     = ce_r;
  assign out_chan.done_res     = done_r;
  assign out_chan.read_data    = read_capture_r;

  // done word shows the link already released
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.done_res |-> !out_chan.chip_enable && !out_chan.io_drive)
    else $error("done word with link still active");

  // the line is only driven inside a transfer
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.io_drive |-> out_chan.busy_res)
    else $error("data line driven outside a transfer");

  // idle link has its bit counter and clock parked
  a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rtcsm_pkg::PH_IDLE |-> bit_index_r == '0 && !clock_half_r)
    else $error("idle phase with bit counter or clock not parked");

  // a start word taken while idle opens the command phase
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !running && (in_chan.action == rtcsm_pkg::ACT_WRITE ||
      in_chan.action == rtcsm_pkg::ACT_READ)
    |=> phase_r == rtcsm_pkg::PH_CMD && out_chan.valid && out_chan.busy_res)
    else $error("start request did not open a transfer");

endmodule

`default_nettype wire
